// File: rtl/qrm_pkg.sv
package qrm_pkg;

  // component and entry widths
  localparam int unsigned CompW = 32;
  localparam int unsigned OutW  = 18;
  localparam int unsigned FracW = 16;

  // matrix entries per item
  localparam int unsigned NumEnt = 9;

  // datapath widths
  localparam int unsigned ProdW = 2 * CompW;              // one component product
  localparam int unsigned SumW  = ProdW + 3;              // signed numerators and n2
  localparam int unsigned N2W   = ProdW + 1;              // magnitude of n2 and numerators
  localparam int unsigned DenW  = N2W + 1;                // 2 * n2
  localparam int unsigned QuoW  = FracW + 1;              // quotient magnitude, up to one
  localparam int unsigned NumW  = N2W + QuoW + 1;         // |num| * 2^17 + n2
  localparam int unsigned DivStages = QuoW;               // one quotient bit per stage

  localparam logic [OutW-1:0] OneQ = OutW'(1) << FracW;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [DenW-1:0]         den_t;
  typedef logic [NumW-1:0]         rem_t;
  typedef logic [QuoW-1:0]         quo_t;
  typedef logic [OutW-1:0]         ent_t;

endpackage

// File: rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix. One quaternion (x, y, z, w, signed Q16.16) goes in per
// item and nine matrix entries (signed Q2.16, rounded to nearest, ties away from zero) come
// out, together with zero_norm, which is set for an all-zero quaternion and then comes with
// the identity matrix. No square root is taken: each entry is an exact ratio of component
// products over n2 = xx + yy + zz + ww, so the input need not be normalised. The block takes
// one item every cycle while the output does not stall, and passes it through one stage of ten
// 32x32 multipliers, one of sums, one that forms dividend and divisor, seventeen stages of a
// restoring divider (one quotient bit each, nine lanes side by side) and the output register.
// A stall on the output side holds the whole pipeline, and in_stall_o is raised only while a
// finished item waits and out_stall_i is high.

module quaternion_to_rotation_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  qrm_pkg::comp_t        comp_x_i,
  input  qrm_pkg::comp_t        comp_y_i,
  input  qrm_pkg::comp_t        comp_z_i,
  input  qrm_pkg::comp_t        comp_w_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output qrm_pkg::ent_t         m00_o,
  output qrm_pkg::ent_t         m01_o,
  output qrm_pkg::ent_t         m02_o,
  output qrm_pkg::ent_t         m10_o,
  output qrm_pkg::ent_t         m11_o,
  output qrm_pkg::ent_t         m12_o,
  output qrm_pkg::ent_t         m20_o,
  output qrm_pkg::ent_t         m21_o,
  output qrm_pkg::ent_t         m22_o,
  output logic                  zero_norm_o
);

  localparam int unsigned NumEnt    = qrm_pkg::NumEnt;
  localparam int unsigned DivStages = qrm_pkg::DivStages;

  // whole pipeline moves unless a finished item is held at the output
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------------------------
  // stage 1: products
  // ---------------------------------------------------------------------------------------
  logic           s1_vld_q;
  qrm_pkg::prod_t xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, xw_q, yz_q, yw_q, zw_q;

  // components sign-extended to product width
  qrm_pkg::prod_t px, py, pz, pw;
  assign px = qrm_pkg::prod_t'(comp_x_i);
  assign py = qrm_pkg::prod_t'(comp_y_i);
  assign pz = qrm_pkg::prod_t'(comp_z_i);
  assign pw = qrm_pkg::prod_t'(comp_w_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= px * px;
      yy_q <= py * py;
      zz_q <= pz * pz;
      ww_q <= pw * pw;
      xy_q <= px * py;
      xz_q <= px * pz;
      xw_q <= px * pw;
      yz_q <= py * pz;
      yw_q <= py * pw;
      zw_q <= pz * pw;
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage 2: signed numerators and n2
  // ---------------------------------------------------------------------------------------
  logic          s2_vld_q;
  qrm_pkg::sum_t n2_q;
  qrm_pkg::sum_t num_q [NumEnt];

  qrm_pkg::sum_t exx, eyy, ezz, eww, exy, exz, exw, eyz, eyw, ezw;
  assign exx = qrm_pkg::SumW'(xx_q);
  assign eyy = qrm_pkg::SumW'(yy_q);
  assign ezz = qrm_pkg::SumW'(zz_q);
  assign eww = qrm_pkg::SumW'(ww_q);
  assign exy = qrm_pkg::SumW'(xy_q);
  assign exz = qrm_pkg::SumW'(xz_q);
  assign exw = qrm_pkg::SumW'(xw_q);
  assign eyz = qrm_pkg::SumW'(yz_q);
  assign eyw = qrm_pkg::SumW'(yw_q);
  assign ezw = qrm_pkg::SumW'(zw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n2_q     <= (exx + eyy) + (ezz + eww);
      num_q[0] <= (exx + eww) - (eyy + ezz);
      num_q[1] <= (exy - ezw) <<< 1;
      num_q[2] <= (exz + eyw) <<< 1;
      num_q[3] <= (exy + ezw) <<< 1;
      num_q[4] <= (eyy + eww) - (exx + ezz);
      num_q[5] <= (eyz - exw) <<< 1;
      num_q[6] <= (exz - eyw) <<< 1;
      num_q[7] <= (eyz + exw) <<< 1;
      num_q[8] <= (ezz + eww) - (exx + eyy);
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage 3: dividend |num| * 2^17 + n2 over divisor 2 * n2, sign kept aside
  // ---------------------------------------------------------------------------------------
  logic                 vld_q  [DivStages+1];
  logic                 zero_q [DivStages+1];
  qrm_pkg::den_t        den_q  [DivStages+1];
  logic [NumEnt-1:0]    neg_q  [DivStages+1];
  qrm_pkg::rem_t        rem_q  [DivStages+1][NumEnt];
  qrm_pkg::quo_t        quo_q  [DivStages+1][NumEnt];

  qrm_pkg::sum_t        mag [NumEnt];
  qrm_pkg::rem_t        dvd [NumEnt];

  always_comb begin
    for (int e = 0; e < NumEnt; e++) begin
      mag[e] = num_q[e][qrm_pkg::SumW-1] ? -num_q[e] : num_q[e];
      dvd[e] = qrm_pkg::NumW'({mag[e][qrm_pkg::N2W-1:0], {qrm_pkg::QuoW{1'b0}}})
             + qrm_pkg::NumW'(n2_q[qrm_pkg::N2W-1:0]);
    end
  end

  // ---------------------------------------------------------------------------------------
  // stages 4 to 20: restoring divider, quotient bit DivStages-1-k decided in stage k
  // ---------------------------------------------------------------------------------------
  logic [qrm_pkg::NumW:0] diff    [DivStages][NumEnt];
  logic [qrm_pkg::NumW:0] den_sh  [DivStages];

  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      den_sh[k] = {{(qrm_pkg::NumW + 1 - qrm_pkg::DenW){1'b0}}, den_q[k]}
                  << (DivStages - 1 - k);
      for (int e = 0; e < NumEnt; e++) begin
        diff[k][e] = {1'b0, rem_q[k][e]} - den_sh[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= s2_vld_q;
      for (int k = 0; k < DivStages; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q[0] <= (n2_q == '0);
      den_q[0]  <= {n2_q[qrm_pkg::N2W-1:0], 1'b0};
      for (int e = 0; e < NumEnt; e++) begin
        neg_q[0][e]    <= num_q[e][qrm_pkg::SumW-1];
        rem_q[0][e]    <= dvd[e];
        quo_q[0][e]    <= '0;
      end
      for (int k = 0; k < DivStages; k++) begin
        zero_q[k+1] <= zero_q[k];
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        for (int e = 0; e < NumEnt; e++) begin
          // borrow clear: the shifted divisor fits, take the difference
          if (!diff[k][e][qrm_pkg::NumW]) begin
            rem_q[k+1][e] <= diff[k][e][qrm_pkg::NumW-1:0];
          end else begin
            rem_q[k+1][e] <= rem_q[k][e];
          end
          quo_q[k+1][e] <= {quo_q[k][e][qrm_pkg::QuoW-2:0], ~diff[k][e][qrm_pkg::NumW]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // output stage: restore sign, identity for a zero quaternion
  // ---------------------------------------------------------------------------------------
  logic          out_vld_q;
  logic          zero_out_q;
  qrm_pkg::ent_t ent_q [NumEnt];
  qrm_pkg::ent_t ent_d [NumEnt];
  qrm_pkg::ent_t qmag  [NumEnt];

  always_comb begin
    for (int e = 0; e < NumEnt; e++) begin
      qmag[e] = qrm_pkg::OutW'(quo_q[DivStages][e]);
      if (zero_q[DivStages]) begin
        ent_d[e] = (e % 4 == 0) ? qrm_pkg::OneQ : '0;
      end else if (neg_q[DivStages][e]) begin
        ent_d[e] = -qmag[e];
      end else begin
        ent_d[e] = qmag[e];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_out_q <= zero_q[DivStages];
      for (int e = 0; e < NumEnt; e++) begin
        ent_q[e] <= ent_d[e];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign zero_norm_o = zero_out_q;
  assign m00_o = ent_q[0];
  assign m01_o = ent_q[1];
  assign m02_o = ent_q[2];
  assign m10_o = ent_q[3];
  assign m11_o = ent_q[4];
  assign m12_o = ent_q[5];
  assign m20_o = ent_q[6];
  assign m21_o = ent_q[7];
  assign m22_o = ent_q[8];

endmodule
